// ===== design/mcdt_pkg.sv =====
// Package for the multi-channel down timer: register map constants,
// word kinds, per-timer command and status structs, address decode.
// No dependencies.
package mcdt_pkg;

  localparam int WORD_W     = 32;
  localparam int MAX_TIMERS = 8;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  // Register map
  localparam logic [7:0] TIMER_SPAN      = 8'h14;
  localparam logic [7:0] GLOBAL_BASE     = 8'hA0;
  localparam logic [7:0] ADDR_INT_STATUS = 8'hA0;
  localparam logic [7:0] ADDR_EOI_ALL    = 8'hA4;
  localparam logic [7:0] ADDR_RAW_STATUS = 8'hA8;

  localparam logic [4:0] OFF_LOAD   = 5'd0;
  localparam logic [4:0] OFF_COUNT  = 5'd4;
  localparam logic [4:0] OFF_CTRL   = 5'd8;
  localparam logic [4:0] OFF_EOI    = 5'd12;
  localparam logic [4:0] OFF_STATUS = 5'd16;

  // Control word bits
  localparam int CTRL_EN   = 0;
  localparam int CTRL_USER = 1;
  localparam int CTRL_MASK = 2;

  typedef struct packed {
    logic              is_global;
    logic [2:0]        tnum;
    logic [4:0]        off;
  } addr_dec_t;

  // Command broadcast to every timer; write and rd_eoi bits qualify with the select
  typedef struct packed {
    logic              tick;
    logic              wr_load;
    logic              wr_ctrl;
    logic              rd_eoi;
    logic              eoi_all;
    logic [WORD_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] load;
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] ctrl;
    logic              pending;
    logic              masked;
    logic              line_lvl;
    logic              line_next;
  } stat_t;

  // Split a byte address into timer number and offset (divide by 0x14)
  function automatic addr_dec_t decode_addr(input logic [7:0] addr);
    addr_dec_t d;
    d.is_global = (addr >= GLOBAL_BASE);
    d.tnum      = 3'd0;
    for (int k = 1; k < MAX_TIMERS; k++) begin
      if (addr >= 8'(k * 20)) begin
        d.tnum = 3'(k);
      end
    end
    d.off = 5'(addr - (8'(d.tnum) * TIMER_SPAN));
    return d;
  endfunction

endpackage

// ===== design/multi_channel_apb_down_timer_unit.sv =====
// Top level of the multi-channel down timer: input register, address
// decode, timer bank, read mux and result register.
// Depends on mcdt_pkg and mcdt_timer.
//
// Usage:
// - Input channel (in_valid/in_stall) carries one word per item: a tick
//   (kind 0), a bus read (kind 1) or a bus write (kind 2) with its byte
//   address and write data. Kind 3 is a no-op that still returns a word.
// - Output channel (out_valid/out_stall) returns exactly one word per
//   item: read_data (zero except for reads) and irq_lines, the level of
//   every timer's interrupt line after the item (bit i = timer i).
// - An accepted item passes through the input register and then the result
//   register, from which its word leaves. Throughput is one item per clock
//   while out_stall is low: the input register feeds one decrement/compare
//   per timer plus a read mux, all finished before the result register.
// - When the receiver stalls, the result register holds its word; the
//   input register still takes one more item, and in_stall rises only
//   when both are full. Timer state advances only when an item moves
//   from the input register to the result register.
// - Reset (rst, synchronous) clears every timer to zero, stopped, with no
//   pending interrupt and all lines low, and empties both registers.
// - Status vectors at 0xA0 (masked) and 0xA8 (raw) put timer 0 at bit
//   NUM_TIMERS-1.
module multi_channel_apb_down_timer_unit #(
  parameter int NUM_TIMERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  address,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic [7:0]  irq_lines
);

  // input register
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [7:0]  s1_addr;
  logic [31:0] s1_data;

  logic accept;
  logic advance;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= kind;
      s1_addr <= address;
      s1_data <= write_data;
    end
  end

  // decode
  mcdt_pkg::addr_dec_t dec;
  mcdt_pkg::cmd_t      cmd;
  logic                is_rd;
  logic                is_wr;
  logic [NUM_TIMERS-1:0] sel;

  assign dec   = mcdt_pkg::decode_addr(s1_addr);
  assign is_rd = (s1_kind == mcdt_pkg::KIND_READ);
  assign is_wr = (s1_kind == mcdt_pkg::KIND_WRITE);

  always_comb begin
    cmd.tick    = (s1_kind == mcdt_pkg::KIND_TICK);
    cmd.wr_load = is_wr && !dec.is_global && dec.off == mcdt_pkg::OFF_LOAD;
    cmd.wr_ctrl = is_wr && !dec.is_global && dec.off == mcdt_pkg::OFF_CTRL;
    cmd.rd_eoi  = is_rd && !dec.is_global && dec.off == mcdt_pkg::OFF_EOI;
    cmd.eoi_all = is_rd && s1_addr == mcdt_pkg::ADDR_EOI_ALL;
    cmd.data    = s1_data;
  end

  // timer bank; an absent timer number selects nothing
  mcdt_pkg::stat_t stat [NUM_TIMERS];

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_tmr
    assign sel[i] = !dec.is_global && dec.tnum == 3'(i);

    mcdt_timer u_tmr (
      .clk  (clk),
      .rst  (rst),
      .go   (advance),
      .sel  (sel[i]),
      .cmd  (cmd),
      .stat (stat[i])
    );
  end

  // read mux
  logic [31:0] rd_timer;
  logic [31:0] vec_masked;
  logic [31:0] vec_raw;
  logic [31:0] rd_next;
  logic [7:0]  irq_next;

  always_comb begin
    rd_timer   = '0;
    vec_masked = '0;
    vec_raw    = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      vec_masked[NUM_TIMERS-1-i] = stat[i].masked;
      vec_raw[NUM_TIMERS-1-i]    = stat[i].pending;
      if (sel[i]) begin
        case (dec.off)
          mcdt_pkg::OFF_LOAD:   rd_timer = stat[i].load;
          mcdt_pkg::OFF_COUNT:  rd_timer = stat[i].count;
          mcdt_pkg::OFF_CTRL:   rd_timer = stat[i].ctrl;
          mcdt_pkg::OFF_STATUS: rd_timer = {31'd0, stat[i].masked};
          default:              rd_timer = '0;
        endcase
      end
    end
  end

  always_comb begin
    rd_next = '0;
    if (is_rd) begin
      if (!dec.is_global) begin
        rd_next = rd_timer;
      end else if (s1_addr == mcdt_pkg::ADDR_INT_STATUS) begin
        rd_next = vec_masked;
      end else if (s1_addr == mcdt_pkg::ADDR_RAW_STATUS) begin
        rd_next = vec_raw;
      end
    end
  end

  always_comb begin
    irq_next = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      irq_next[i] = stat[i].line_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data <= rd_next;
      irq_lines <= irq_next;
    end
  end

  // checks
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item left input register without a result");

  a_eoi_all: assert property (@(posedge clk) disable iff (rst)
    advance && cmd.eoi_all |=> irq_lines == 8'd0)
    else $error("global eoi left a line high");

  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    advance && !is_rd |=> read_data == 32'd0)
    else $error("non-read item returned data");

  a_irq_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq_lines >> NUM_TIMERS) == 8'd0)
    else $error("line set for absent timer");

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_chk
    a_line_pend: assert property (@(posedge clk) disable iff (rst)
      stat[i].line_lvl |-> stat[i].pending)
      else $error("interrupt line high without pending status");
  end

endmodule

// ===== design/mcdt_timer.sv =====
// One down-counting timer channel: load, count, limit, control and
// interrupt state with its tick and register-write logic.
// Depends on mcdt_pkg.
module mcdt_timer (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic            sel,
  input  mcdt_pkg::cmd_t  cmd,
  output mcdt_pkg::stat_t stat
);

  logic [31:0] load,  load_next;
  logic [31:0] count, count_next;
  logic [31:0] limit, limit_next;
  logic [31:0] ctrl,  ctrl_next;
  logic        running, running_next;
  logic        pending, pending_next;
  logic        line_lvl, line_lvl_next;
  logic [31:0] tick_val;

  assign tick_val = (count == 32'd0) ? limit : count - 32'd1;

  always_comb begin
    load_next     = load;
    count_next    = count;
    limit_next    = limit;
    ctrl_next     = ctrl;
    running_next  = running;
    pending_next  = pending;
    line_lvl_next = line_lvl;
    if (cmd.tick && running) begin
      count_next = tick_val;
      if (tick_val == 32'd0) begin
        if (ctrl[mcdt_pkg::CTRL_USER] && limit == 32'd0) begin
          running_next = 1'b0;
        end
        pending_next  = 1'b1;
        line_lvl_next = !ctrl[mcdt_pkg::CTRL_MASK];
      end
    end
    if (sel && cmd.wr_load) begin
      load_next  = cmd.data;
      count_next = cmd.data;
    end
    if (sel && cmd.wr_ctrl) begin
      // mode or enable change restarts the timer with a fresh limit
      if (ctrl[1:0] != cmd.data[1:0]) begin
        limit_next   = cmd.data[mcdt_pkg::CTRL_USER] ? load : '1;
        running_next = cmd.data[mcdt_pkg::CTRL_EN];
      end
      ctrl_next = cmd.data;
    end
    if (sel && cmd.rd_eoi) begin
      pending_next  = 1'b0;
      line_lvl_next = 1'b0;
    end
    if (cmd.eoi_all) begin
      line_lvl_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load     <= '0;
      count    <= '0;
      limit    <= '0;
      ctrl     <= '0;
      running  <= 1'b0;
      pending  <= 1'b0;
      line_lvl <= 1'b0;
    end else if (go) begin
      load     <= load_next;
      count    <= count_next;
      limit    <= limit_next;
      ctrl     <= ctrl_next;
      running  <= running_next;
      pending  <= pending_next;
      line_lvl <= line_lvl_next;
    end
  end

  always_comb begin
    stat.load      = load;
    stat.count     = count;
    stat.ctrl      = ctrl;
    stat.pending   = pending;
    stat.masked    = pending && !ctrl[mcdt_pkg::CTRL_MASK];
    stat.line_lvl  = line_lvl;
    stat.line_next = line_lvl_next;
  end

endmodule

// ===== dv/tb_multi_channel_apb_down_timer_unit.sv =====
// Self-checking bench for multi_channel_apb_down_timer_unit: directed and random
// tick/read/write words, checked one for one against a cycle-free timer bank model.
// Depends on mcdt_pkg and the timer unit RTL.
module tb_multi_channel_apb_down_timer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mcdt_pkg::*;

  localparam int NUM_TIMERS   = 8;
  localparam int HALF_PERIOD  = 1;
  localparam int RANDOM_WORDS = 900;
  localparam int IDLE_PCT     = 36;
  localparam int STUCK_LIMIT  = 1000;   // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 8;      // idle cycles waited after the last result is back
  localparam int HOLD_LEN     = 60;     // long receiver hold-off
  localparam int HOLD_AT_A    = 300;
  localparam int HOLD_AT_B    = 1600;
  localparam int CALM_FROM    = 800;    // window where neither side idles
  localparam int CALM_TO      = 1300;
  localparam int MAX_PRINTS   = 50;

  // kind 3 has no enum member; it is a legal no-op word
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  addr;
    logic [31:0] data;
  } bus_word_t;

  typedef struct {
    logic [31:0] rdata;
    logic [7:0]  lines;
  } bank_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_TICK;
  logic [7:0]  address = '0;
  logic [31:0] write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic [7:0]  irq_lines;

  multi_channel_apb_down_timer_unit #(.NUM_TIMERS(NUM_TIMERS)) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .irq_lines  (irq_lines)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Free-running cycle count; drives the calm window and the hold-off triggers.
  int unsigned cycle_no = 0;
  always @(posedge clk) cycle_no <= cycle_no + 1;

  logic calm;
  assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

  int unsigned hold_left = 0;   // receiver hold-off countdown, owned by the monitor
  int unsigned errors = 0;

  bus_word_t  stim_q[$];          // words still to be offered
  bank_resp_t bank_responses[$];  // predicted results, oldest first

  // ---------------------------------------------------------------------------
  // Timer bank model state, one entry per timer
  // ---------------------------------------------------------------------------
  logic [31:0] m_load  [MAX_TIMERS];
  logic [31:0] m_count [MAX_TIMERS];
  logic [31:0] m_limit [MAX_TIMERS];
  logic [31:0] m_ctrl  [MAX_TIMERS];
  logic        m_run   [MAX_TIMERS];
  logic        m_pend  [MAX_TIMERS];
  logic        m_line  [MAX_TIMERS];

  initial begin
    for (int i = 0; i < MAX_TIMERS; i++) begin
      m_load[i]  = '0;
      m_count[i] = '0;
      m_limit[i] = '0;
      m_ctrl[i]  = '0;
      m_run[i]   = 1'b0;
      m_pend[i]  = 1'b0;
      m_line[i]  = 1'b0;
    end
  end

  // Status as seen through the mask bit.
  function automatic logic masked_int(int t);
    return m_pend[t] && !m_ctrl[t][CTRL_MASK];
  endfunction

  // Apply one accepted word to the model and return the result it produces.
  function automatic bank_resp_t advance_bank(logic [1:0] k, logic [7:0] a, logic [31:0] d);
    bank_resp_t  r;
    int          t;
    logic [4:0]  off;
    logic [31:0] nxt;
    r.rdata = '0;
    r.lines = '0;
    t   = int'(a) / int'(TIMER_SPAN);
    off = 5'(int'(a) % int'(TIMER_SPAN));
    case (k)
      KIND_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (m_run[i]) begin
            // a counter sitting at zero reloads instead of wrapping
            nxt = (m_count[i] == '0) ? m_limit[i] : m_count[i] - 32'd1;
            m_count[i] = nxt;
            if (nxt == '0) begin
              // user mode with a zero limit fires once and stops
              if (m_ctrl[i][CTRL_USER] && m_limit[i] == '0) m_run[i] = 1'b0;
              m_pend[i] = 1'b1;
              m_line[i] = masked_int(i);
            end
          end
        end
      end
      KIND_READ: begin
        if (a < GLOBAL_BASE) begin
          if (t < NUM_TIMERS) begin
            case (off)
              OFF_LOAD:   r.rdata = m_load[t];
              OFF_COUNT:  r.rdata = m_count[t];
              OFF_CTRL:   r.rdata = m_ctrl[t];
              OFF_EOI: begin
                m_pend[t] = 1'b0;
                m_line[t] = 1'b0;
              end
              OFF_STATUS: r.rdata = {31'd0, masked_int(t)};
              default:    r.rdata = '0;
            endcase
          end
        end else if (a == ADDR_EOI_ALL) begin
          // drops lines only; pending bits stay
          for (int i = 0; i < MAX_TIMERS; i++) m_line[i] = 1'b0;
        end else if (a == ADDR_INT_STATUS || a == ADDR_RAW_STATUS) begin
          // timer 0 lands in bit NUM_TIMERS-1 of the vector
          for (int i = 0; i < NUM_TIMERS; i++)
            r.rdata = {r.rdata[30:0], (a == ADDR_INT_STATUS) ? masked_int(i) : m_pend[i]};
        end
      end
      KIND_WRITE: begin
        if (a < GLOBAL_BASE && t < NUM_TIMERS) begin
          if (off == OFF_LOAD) begin
            m_load[t]  = d;
            m_count[t] = d;
          end else if (off == OFF_CTRL) begin
            // mode/enable change restarts the timer with the new limit
            if (m_ctrl[t][1:0] != d[1:0]) begin
              m_run[t]   = 1'b0;
              m_limit[t] = d[CTRL_USER] ? m_load[t] : 32'hFFFF_FFFF;
              if (d[CTRL_EN]) m_run[t] = 1'b1;
            end
            m_ctrl[t] = d;
          end
        end
      end
      default: ;  // no-op word
    endcase
    for (int i = 0; i < NUM_TIMERS; i++) r.lines[i] = m_line[i];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] reg_addr(int t, logic [4:0] off);
    return 8'(t * int'(TIMER_SPAN) + int'(off));
  endfunction

  function automatic void push_word(logic [1:0] k, logic [7:0] a, logic [31:0] d);
    stim_q.push_back('{k, a, d});
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers words from stim_q, holds a stalled word steady, and feeds
  // the model at each accept. Never idles during a receiver hold-off so the
  // unit fills and pushes back on its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    bus_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) bank_responses.push_back(advance_bank(kind, address, write_data));
      if (stim_q.size() != 0 &&
          (hold_left != 0 || calm || $urandom_range(99) >= IDLE_PCT)) begin
        w = stim_q.pop_front();
        in_valid   <= 1'b1;
        kind       <= w.kind;
        address    <= w.addr;
        write_data <= w.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest prediction and
  // drives out_stall (random, calm window, long hold-offs).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    bank_resp_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bank_responses.size() == 0) begin
          report_mismatch("result word with nothing due", read_data, '0);
        end else begin
          want = bank_responses.pop_front();
          if (read_data !== want.rdata) report_mismatch("read_data", read_data, want.rdata);
          if (irq_lines !== want.lines)
            report_mismatch("irq_lines", {24'd0, irq_lines}, {24'd0, want.lines});
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (cycle_no == HOLD_AT_A || cycle_no == HOLD_AT_B) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_LEN;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: ends the run if no word moves for too long.
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          n;
    int          t;
    int          nt;
    logic [31:0] lim;
    logic [31:0] ctl;
    logic [7:0]  ra;

    // Directed: extreme data, every kind, zero-limit user mode, masking,
    // per-timer and global EOI, ignored writes, unaligned and unmapped reads.
    push_word(KIND_WRITE, reg_addr(0, OFF_LOAD), 32'hFFFF_FFFF);
    push_word(KIND_READ,  reg_addr(0, OFF_LOAD), '0);
    push_word(KIND_WRITE, reg_addr(0, OFF_CTRL), 32'h1);        // free mode, enabled
    push_word(KIND_WRITE, reg_addr(7, OFF_LOAD), 32'd3);
    push_word(KIND_WRITE, reg_addr(7, OFF_CTRL), 32'h3);        // user mode, periodic
    push_word(KIND_WRITE, reg_addr(1, OFF_LOAD), '0);
    push_word(KIND_WRITE, reg_addr(1, OFF_CTRL), 32'h3);        // user mode, zero limit
    push_word(KIND_WRITE, reg_addr(2, OFF_LOAD), 32'd1);
    push_word(KIND_WRITE, reg_addr(2, OFF_CTRL), 32'h7);        // masked
    push_word(KIND_WRITE, reg_addr(3, OFF_CTRL), 32'hFFFF_FFFF);
    repeat (4) push_word(KIND_TICK, '0, '0);
    push_word(KIND_READ,  ADDR_INT_STATUS, '0);
    push_word(KIND_READ,  ADDR_RAW_STATUS, '0);
    push_word(KIND_READ,  reg_addr(7, OFF_STATUS), '0);
    push_word(KIND_READ,  reg_addr(7, OFF_EOI), '0);
    push_word(KIND_READ,  ADDR_EOI_ALL, '0);
    push_word(KIND_READ,  reg_addr(0, OFF_COUNT), '0);
    push_word(KIND_WRITE, reg_addr(0, OFF_COUNT), '0);           // ignored
    push_word(KIND_WRITE, ADDR_INT_STATUS, 32'hFFFF_FFFF);       // ignored
    push_word(KIND_READ,  8'h02, '0);                            // unaligned
    push_word(KIND_READ,  8'hFF, '0);                            // unmapped
    push_word(KIND_NOP,   8'hFF, 32'hFFFF_FFFF);
    push_word(KIND_WRITE, reg_addr(0, OFF_CTRL), '0);            // stop timer 0

    // Random: mostly program-then-run sequences with short limits so counters
    // actually hit zero; the rest is raw noise over all kinds and addresses.
    n = 0;
    while (n < RANDOM_WORDS) begin
      if ($urandom_range(99) < 65) begin
        t   = $urandom_range(NUM_TIMERS - 1);
        lim = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(12));
        ctl = $urandom;
        ctl[CTRL_EN]   = ($urandom_range(99) < 85);
        ctl[CTRL_USER] = $urandom_range(1);
        ctl[CTRL_MASK] = ($urandom_range(99) < 30);
        push_word(KIND_WRITE, reg_addr(t, OFF_LOAD), lim);
        push_word(KIND_WRITE, reg_addr(t, OFF_CTRL), ctl);
        n += 2;
        nt = $urandom_range(14, 1);
        repeat (nt) begin
          push_word(KIND_TICK, 8'($urandom_range(255)), $urandom);
          n++;
          if ($urandom_range(99) < 25) begin
            case ($urandom_range(3))
              0:       ra = reg_addr(t, OFF_STATUS);
              1:       ra = reg_addr(t, OFF_COUNT);
              2:       ra = ADDR_INT_STATUS;
              default: ra = ADDR_RAW_STATUS;
            endcase
            push_word(KIND_READ, ra, $urandom);
            n++;
          end
        end
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            push_word(KIND_READ, reg_addr(t, OFF_EOI), '0);
            n++;
          end
          5, 6: begin
            push_word(KIND_READ, ADDR_EOI_ALL, '0);
            n++;
          end
          default: ;
        endcase
      end else begin
        case ($urandom_range(3))
          0: push_word(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom);
          1: push_word(KIND_READ,
                       reg_addr($urandom_range(NUM_TIMERS - 1), 5'($urandom_range(19))),
                       $urandom);
          2: push_word(KIND_WRITE, reg_addr($urandom_range(NUM_TIMERS - 1), OFF_CTRL),
                       $urandom);
          default: push_word(KIND_TICK, 8'($urandom_range(255)), $urandom);
        endcase
        n++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain: every word offered and every result back, then a few idle cycles
    // to catch any stray result.
    while (stim_q.size() != 0 || in_valid || bank_responses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mcdt_pkg.sv
design/mcdt_timer.sv
design/multi_channel_apb_down_timer_unit.sv
dv/tb_multi_channel_apb_down_timer_unit.sv
